/* hdl/tcba_pkg.sv */
package tcba_pkg;

   // Fixed field widths of the request and response
   localparam int WANT_W    = 14;
   localparam int TIME_IN_W = 32;
   localparam int FIRST_W   = 13;

   // Request tdata layout, lowest bit first
   localparam int WANT_LSB     = 0;
   localparam int REQ_TIME_LSB = WANT_LSB + WANT_W;
   localparam int HOLD_LSB     = REQ_TIME_LSB + TIME_IN_W;
   localparam int REQ_BITS     = HOLD_LSB + TIME_IN_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((FIRST_W + 7) / 8) * 8;

   // Default sizing
   localparam int DEF_NUM_BLOCKS = 8192;
   localparam int DEF_TIME_BITS  = 32;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DECIDE,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;        // capture request, reset scan state
      logic scan_active;  // read and evaluate blocks
      logic load_wr;      // load write pointer with the chosen start
      logic wr_active;    // mark one granted block per cycle
      logic clr_active;   // zero one entry per cycle after reset
      logic rsp_load;     // move result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic want_ok;
      logic scan_hit;
      logic scan_end;
      logic have;
      logic wr_last;
      logic clr_last;
      logic rsp_free;
   } sts_type;

endpackage

/* hdl/tcba_ctrl.sv */
module tcba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  tcba_pkg::sts_type sts,
   output tcba_pkg::cmd_type cmd
);
   import tcba_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_tready      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_active = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.want_ok ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_active = 1'b1;
            if (sts.scan_hit || sts.scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.have) begin
               cmd.load_wr = 1'b1;
               state_in    = ST_WRITE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.wr_active = 1'b1;
            if (sts.wr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Marking only happens for a found run
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> sts.have)
      else $error("write pass without a found run");

   // Scan always ends through the decision step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && (sts.scan_hit || sts.scan_end)) |=> (state_ff == ST_DECIDE))
      else $error("scan exit skipped decision");

   // Clearing pass runs only once after reset
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass re-entered");

endmodule

/* hdl/tcba_datapath.sv */
module tcba_datapath #(
   parameter int NUM_BLOCKS = tcba_pkg::DEF_NUM_BLOCKS,
   parameter int TIME_BITS  = tcba_pkg::DEF_TIME_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tcba_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             fit_mode,
   input  tcba_pkg::cmd_type                cmd,
   output tcba_pkg::sts_type                sts,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                       rsp_tuser
);
   import tcba_pkg::*;

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > WANT_W) ? CNT_W : WANT_W;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_BLOCKS - 1);
   localparam logic [CNT_W-1:0] END_IDX  = CNT_W'(NUM_BLOCKS);

   // Busy-until store
   logic [TIME_BITS-1:0] mem [NUM_BLOCKS];

   // Captured request
   logic [WANT_W-1:0]    want_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] dur_ff;
   logic                 mode_ff;
   logic [TIME_BITS-1:0] until_ff;

   // Scan and write pointers
   logic [CNT_W-1:0]     addr_ff, addr_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic                 rd_vld_ff;
   logic [CNT_W-1:0]     rd_idx_ff;
   logic [TIME_BITS-1:0] rd_data_ff;

   // Run tracking
   logic [CNT_W-1:0] run_ff, run_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] best_len_ff, best_len_in;
   logic [IDX_W-1:0] best_head_ff, best_head_in;
   logic             have_ff, have_in;

   // Output register
   logic                   rsp_valid_ff;
   logic                   rsp_granted_ff;
   logic [FIRST_W-1:0]     rsp_first_ff;

   logic                   rd_fire;
   logic                   eval_en;
   logic                   blk_free;
   logic [CNT_W-1:0]       run_inc;
   logic [IDX_W-1:0]       head_nx;
   logic                   mem_wr_en;
   logic [TIME_BITS-1:0]   mem_wr_data;
   logic [TIME_BITS:0]     end_sum;
   logic [TIME_IN_W+TIME_BITS-1:0] now_wide;
   logic [TIME_IN_W+TIME_BITS-1:0] dur_wide;
   logic [FIRST_W+IDX_W-1:0]       first_wide;

   assign now_wide   = {{TIME_BITS{1'b0}}, req_tdata[REQ_TIME_LSB +: TIME_IN_W]};
   assign dur_wide   = {{TIME_BITS{1'b0}}, req_tdata[HOLD_LSB +: TIME_IN_W]};
   assign first_wide = {{FIRST_W{1'b0}}, best_head_ff};

   // Request capture and saturated end time
   assign end_sum = {1'b0, now_ff} + {1'b0, dur_ff};
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         want_ff <= req_tdata[WANT_LSB +: WANT_W];
         now_ff  <= now_wide[TIME_BITS-1:0];
         dur_ff  <= dur_wide[TIME_BITS-1:0];
         mode_ff <= fit_mode;
      end
      until_ff <= end_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : end_sum[TIME_BITS-1:0];
   end

   // Memory port: one write, one registered read
   assign rd_fire     = cmd.scan_active && (addr_ff <= END_IDX);
   assign mem_wr_en   = cmd.clr_active || cmd.wr_active;
   assign mem_wr_data = cmd.clr_active ? '0 : until_ff;
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[addr_ff[IDX_W-1:0]] <= mem_wr_data;
      end
      rd_data_ff <= mem[addr_ff[IDX_W-1:0]];
      rd_idx_ff  <= addr_ff;
   end

   // Pointer and remaining count
   always_comb begin
      addr_in = addr_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         addr_in = '0;
      end else if (cmd.load_wr) begin
         addr_in = CNT_W'(best_head_ff);
         rem_in  = CNT_W'(want_ff);
      end else if (cmd.wr_active) begin
         addr_in = addr_ff + 1'b1;
         rem_in  = rem_ff - 1'b1;
      end else if (rd_fire || cmd.clr_active) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rem_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         rem_ff    <= rem_in;
         rd_vld_ff <= rd_fire;
      end
   end

   // Run evaluation, one block per cycle; the end index closes the last run
   assign eval_en  = cmd.scan_active && rd_vld_ff;
   assign blk_free = (rd_idx_ff != END_IDX) && (now_ff >= rd_data_ff);
   assign run_inc  = run_ff + 1'b1;
   assign head_nx  = (run_ff == '0) ? rd_idx_ff[IDX_W-1:0] : head_ff;

   always_comb begin
      run_in       = run_ff;
      head_in      = head_ff;
      best_len_in  = best_len_ff;
      best_head_in = best_head_ff;
      have_in      = have_ff;
      if (cmd.start) begin
         run_in       = '0;
         head_in      = '0;
         best_len_in  = '0;
         best_head_in = '0;
         have_in      = 1'b0;
      end else if (eval_en) begin
         if (blk_free) begin
            head_in = head_nx;
            run_in  = run_inc;
            if (!mode_ff && (CMP_W'(run_inc) >= CMP_W'(want_ff))) begin
               have_in      = 1'b1;
               best_head_in = head_nx;
               best_len_in  = run_inc;
            end
         end else begin
            if (mode_ff && (CMP_W'(run_ff) >= CMP_W'(want_ff)) &&
                (!have_ff || (run_ff < best_len_ff))) begin
               have_in      = 1'b1;
               best_len_in  = run_ff;
               best_head_in = head_ff;
            end
            run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      run_ff       <= run_in;
      head_ff      <= head_in;
      best_len_ff  <= best_len_in;
      best_head_ff <= best_head_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_granted_ff <= have_ff;
         rsp_first_ff   <= have_ff ? first_wide[FIRST_W-1:0] : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_TDATA_W'(rsp_first_ff);
   assign rsp_tuser[0] = rsp_granted_ff;

   // Status
   assign sts.want_ok  = (want_ff != '0) && (CMP_W'(want_ff) <= CMP_W'(NUM_BLOCKS));
   assign sts.scan_hit = eval_en && blk_free && !mode_ff &&
                         (CMP_W'(run_inc) >= CMP_W'(want_ff));
   assign sts.scan_end = eval_en && (rd_idx_ff == END_IDX);
   assign sts.have     = have_ff;
   assign sts.wr_last  = (rem_ff == CNT_W'(1));
   assign sts.clr_last = (addr_ff == LAST_IDX);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   // Scan reads and store writes never share the port
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && rd_fire))
      else $error("memory read and write in the same cycle");

   // A pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // A chosen run is always long enough
   assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (CMP_W'(best_len_ff) >= CMP_W'(want_ff)))
      else $error("chosen run shorter than request");

   // Marking stays inside the store
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_active |-> (addr_ff < END_IDX))
      else $error("write pass past last block");

endmodule

/* hdl/timed_contiguous_block_allocator.sv */
// Worst case per request: a full scan plus marking; first fit stops the scan
// at the first run that fits. Throughput: one request at a time, set by the
// single memory port: one block read per cycle in the scan, one block written
// per cycle in marking.
// Reset: synchronous; fit_mode goes to first fit and a clearing pass zeroes the store
// before the first request is accepted.
module timed_contiguous_block_allocator #(
   parameter int NUM_BLOCKS = tcba_pkg::DEF_NUM_BLOCKS,
   parameter int TIME_BITS  = tcba_pkg::DEF_TIME_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: blocks_wanted[13:0], request_time[45:14], hold_duration[77:46], zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tcba_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tdata: first_block[12:0], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcba_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: granted[0]
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [0:0]                       csr_wr_data
);
   import tcba_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    fit_mode_ff;

   // Mode register: 0 first fit, 1 best fit
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         fit_mode_ff <= csr_wr_data[0];
      end
   end

   tcba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .fit_mode   (fit_mode_ff),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
